FILE: rtl/wfm_pkg.sv
// Shared types and constants for the 802.11 frame monitor.
// No dependencies; imported by the table, the lookup engine, the top level and the testbench.
package wfm_pkg;

  // 48-bit station or BSSID address
  typedef logic [47:0] mac_t;

  // Status word from the lookup engine to the sequencer
  typedef struct packed {
    logic done;
    logic hit;
  } srch_stat_t;

  // Input word selector
  localparam logic FUNC_BYTE  = 1'b0;
  localparam logic FUNC_EPOCH = 1'b1;

  // Radio frame classes that are tracked
  localparam logic [1:0] KIND_MGMT = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;

  // Report kinds
  localparam logic REPORT_FRAME = 1'b0;
  localparam logic REPORT_EPOCH = 1'b1;

  // Frame control and EAPOL byte values
  localparam logic [7:0] BEACON_FC  = 8'h80;
  localparam logic [7:0] DTYPE_MASK = 8'h0C;
  localparam logic [7:0] DTYPE_VAL  = 8'h08;
  localparam logic [7:0] EAPOL_HI   = 8'h88;
  localparam logic [7:0] EAPOL_LO   = 8'h8E;

  // Byte offset tracking: saturates well above every threshold
  localparam int OFF_W = 6;
  localparam logic [OFF_W-1:0] OFF_MAX = '1;

  // Offsets and length thresholds
  localparam int SRC_FIRST      = 10;
  localparam int SRC_LAST       = 15;
  localparam int BSSID_FIRST    = 16;
  localparam int BSSID_LAST     = 21;
  localparam int EAPOL_MIN_OFF  = 25;
  localparam int COUNT_MIN_LEN  = 24;
  localparam int BEACON_MIN_LEN = 36;

endpackage

FILE: rtl/wfm_table.sv
// Address table storage: one write port, one registered read port.
// Depends on wfm_pkg for the address type.
module wfm_table #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  wfm_pkg::mac_t     wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output wfm_pkg::mac_t     rd_data
);
  import wfm_pkg::*;

  mac_t mem [DEPTH];
  mac_t rd_data_r;

  // Write new entries
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/wfm_search.sv
// Lookup engine: walks a table one entry per cycle with a single comparator.
// Depends on wfm_pkg; reads through a registered memory port.
module wfm_search #(
  parameter int CNT_W  = 8,
  parameter int ADDR_W = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  wfm_pkg::mac_t       key,
  input  logic [CNT_W-1:0]    fill,
  input  wfm_pkg::mac_t       rd_data,
  output logic [ADDR_W-1:0]   rd_addr,
  output wfm_pkg::srch_stat_t stat
);
  import wfm_pkg::*;

  logic             busy_r, busy_nxt;
  logic             pend_r, pend_nxt;
  logic             done_r, done_nxt;
  logic             hit_r, hit_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             issue, match, finish;

  // Issue one read per cycle, compare the word read in the previous cycle
  always_comb begin
    issue    = busy_r && (idx_r < fill);
    match    = busy_r && pend_r && (rd_data == key);
    finish   = busy_r && (match || (!issue && !pend_r));
    busy_nxt = busy_r;
    pend_nxt = 1'b0;
    idx_nxt  = idx_r;
    done_nxt = finish;
    hit_nxt  = finish ? match : hit_r;
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (busy_r) begin
      idx_nxt  = idx_r + CNT_W'(issue);
      pend_nxt = issue && !match;
      if (finish) begin
        busy_nxt = 1'b0;
        pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      done_r <= 1'b0;
      hit_r  <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      done_r <= done_nxt;
      hit_r  <= hit_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign rd_addr   = idx_r[ADDR_W-1:0];
  assign stat.done = done_r;
  assign stat.hit  = hit_r;

endmodule

FILE: rtl/wifi_frame_monitor_core.sv
// A frame byte that is not the last is taken while idle, and the input stays ready.
// Last byte with no lookup, or an epoch tick: S_DONE loads the output register once it is free,
// then S_IDLE. Last byte with a lookup: S_SRCH first, set by the single comparator walking
// the table one entry per cycle through the registered memory read port.
// Reset (rst_n, synchronous, active low) clears control, counters and fill levels;
// table contents are not cleared and entries at or above the fill level are never compared.
module wifi_frame_monitor_core #(
  parameter int AP_ENTRIES     = 64,
  parameter int CLIENT_ENTRIES = 128
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_func,
  input  logic [7:0]                           in_data_byte,
  input  logic [1:0]                           in_frame_kind,
  input  logic                                 in_last_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_report_kind,
  output logic                                 out_frame_counted,
  output logic                                 out_new_ap,
  output logic                                 out_new_client,
  output logic                                 out_handshake_seen,
  output logic                                 out_table_full,
  output logic [$clog2(AP_ENTRIES+1)-1:0]      out_ap_total,
  output logic [$clog2(CLIENT_ENTRIES+1)-1:0]  out_client_total,
  output logic [31:0]                          out_handshake_total,
  output logic [31:0]                          out_activity_count
);
  import wfm_pkg::*;

  localparam int AP_CW = $clog2(AP_ENTRIES + 1);
  localparam int CL_CW = $clog2(CLIENT_ENTRIES + 1);
  localparam int AP_AW = (AP_ENTRIES > 1) ? $clog2(AP_ENTRIES) : 1;
  localparam int CL_AW = (CLIENT_ENTRIES > 1) ? $clog2(CLIENT_ENTRIES) : 1;
  localparam int MAX_N = (AP_ENTRIES > CLIENT_ENTRIES) ? AP_ENTRIES : CLIENT_ENTRIES;
  localparam int S_CW  = $clog2(MAX_N + 1);
  localparam int S_AW  = (MAX_N > 1) ? $clog2(MAX_N) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SRCH = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [7:0]       first_r, first_nxt;
  logic [7:0]       prev_r, prev_nxt;
  logic             eap_r, eap_nxt, eap_cur;
  mac_t             src_r, src_nxt, src_cur;
  mac_t             bssid_r, bssid_nxt, bssid_cur;
  mac_t             key_r, key_nxt;
  logic [AP_CW-1:0] ap_fill_r, ap_fill_nxt;
  logic [CL_CW-1:0] cl_fill_r, cl_fill_nxt;
  logic [31:0]      hs_cnt_r, hs_cnt_nxt;
  logic [31:0]      act_r, act_nxt;

  // Pending result
  logic             rk_r, rk_nxt;
  logic             cnt_r, cnt_nxt;
  logic             nap_r, nap_nxt;
  logic             ncl_r, ncl_nxt;
  logic             hs_r, hs_nxt;
  logic             full_r, full_nxt;
  logic             sel_r, sel_nxt;

  // Output register
  logic             ov_r, ov_nxt;
  logic             o_rk_r, o_cnt_r, o_nap_r, o_ncl_r, o_hs_r, o_full_r;
  logic [AP_CW-1:0] o_ap_r;
  logic [CL_CW-1:0] o_cl_r;
  logic [31:0]      o_hs_tot_r, o_act_r;
  logic             load;

  // Decode
  logic             acc, kind_ok, counted, is_beacon, is_dtype;
  logic             srch_start;
  logic             ap_we, cl_we;
  logic [S_CW-1:0]  srch_fill;
  logic [S_AW-1:0]  srch_addr;
  mac_t             ap_rdata, cl_rdata, srch_rdata;
  srch_stat_t       srch_stat;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;

  // Capture frame bytes, sequence lookups and load the output word
  always_comb begin
    state_nxt   = state_r;
    off_nxt     = off_r;
    first_nxt   = first_r;
    prev_nxt    = prev_r;
    eap_nxt     = eap_r;
    src_nxt     = src_r;
    bssid_nxt   = bssid_r;
    key_nxt     = key_r;
    ap_fill_nxt = ap_fill_r;
    cl_fill_nxt = cl_fill_r;
    hs_cnt_nxt  = hs_cnt_r;
    act_nxt     = act_r;
    rk_nxt      = rk_r;
    cnt_nxt     = cnt_r;
    nap_nxt     = nap_r;
    ncl_nxt     = ncl_r;
    hs_nxt      = hs_r;
    full_nxt    = full_r;
    sel_nxt     = sel_r;
    ov_nxt      = ov_r && !out_ready;
    load        = 1'b0;
    srch_start  = 1'b0;
    ap_we       = 1'b0;
    cl_we       = 1'b0;

    // Byte capture for the word on the input
    first_nxt = (off_r == '0) ? in_data_byte : first_r;
    src_cur   = (off_r inside {[SRC_FIRST:SRC_LAST]}) ? {src_r[39:0], in_data_byte} : src_r;
    bssid_cur = (off_r inside {[BSSID_FIRST:BSSID_LAST]}) ?
                {bssid_r[39:0], in_data_byte} : bssid_r;
    eap_cur   = eap_r || ((off_r >= OFF_W'(EAPOL_MIN_OFF)) && (prev_r == EAPOL_HI) &&
                          (in_data_byte == EAPOL_LO));
    kind_ok   = (in_frame_kind == KIND_MGMT) || (in_frame_kind == KIND_DATA);
    counted   = kind_ok && (off_r >= OFF_W'(COUNT_MIN_LEN - 1));
    is_beacon = counted && (first_nxt == BEACON_FC) && (off_r >= OFF_W'(BEACON_MIN_LEN));
    is_dtype  = counted && ((first_nxt & DTYPE_MASK) == DTYPE_VAL);
    if (!acc || in_func == FUNC_EPOCH) begin
      first_nxt = first_r;
    end

    case (state_r)
      S_IDLE: begin
        if (acc && in_func == FUNC_EPOCH) begin
          rk_nxt    = REPORT_EPOCH;
          cnt_nxt   = 1'b0;
          nap_nxt   = 1'b0;
          ncl_nxt   = 1'b0;
          hs_nxt    = 1'b0;
          full_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else if (acc) begin
          src_nxt   = src_cur;
          bssid_nxt = bssid_cur;
          if (!in_last_byte) begin
            // Advance within the frame
            prev_nxt = in_data_byte;
            eap_nxt  = eap_cur;
            off_nxt  = (off_r == OFF_MAX) ? off_r : off_r + OFF_W'(1);
          end else begin
            // End of frame: count, then look up if an address is tracked
            prev_nxt = '0;
            eap_nxt  = 1'b0;
            off_nxt  = '0;
            rk_nxt   = REPORT_FRAME;
            cnt_nxt  = counted;
            nap_nxt  = 1'b0;
            ncl_nxt  = 1'b0;
            full_nxt = 1'b0;
            hs_nxt   = is_dtype && eap_cur;
            if (counted && act_r != '1) begin
              act_nxt = act_r + 32'd1;
            end
            if (is_dtype && eap_cur) begin
              hs_cnt_nxt = hs_cnt_r + 32'd1;
            end
            sel_nxt = is_dtype;
            key_nxt = is_dtype ? src_cur : bssid_cur;
            if (is_beacon || is_dtype) begin
              srch_start = 1'b1;
              state_nxt  = S_SRCH;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_SRCH: begin
        // Insert an unseen address, or flag a full table
        if (srch_stat.done) begin
          if (!srch_stat.hit) begin
            if (sel_r) begin
              if (cl_fill_r < CL_CW'(CLIENT_ENTRIES)) begin
                cl_we       = 1'b1;
                cl_fill_nxt = cl_fill_r + CL_CW'(1);
                ncl_nxt     = 1'b1;
              end else begin
                full_nxt = 1'b1;
              end
            end else begin
              if (ap_fill_r < AP_CW'(AP_ENTRIES)) begin
                ap_we       = 1'b1;
                ap_fill_nxt = ap_fill_r + AP_CW'(1);
                nap_nxt     = 1'b1;
              end else begin
                full_nxt = 1'b1;
              end
            end
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!ov_r || out_ready) begin
          load      = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
          if (rk_r == REPORT_EPOCH) begin
            act_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      off_r     <= '0;
      first_r   <= '0;
      prev_r    <= '0;
      eap_r     <= 1'b0;
      src_r     <= '0;
      bssid_r   <= '0;
      ap_fill_r <= '0;
      cl_fill_r <= '0;
      hs_cnt_r  <= '0;
      act_r     <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      off_r     <= off_nxt;
      first_r   <= first_nxt;
      prev_r    <= prev_nxt;
      eap_r     <= eap_nxt;
      src_r     <= src_nxt;
      bssid_r   <= bssid_nxt;
      ap_fill_r <= ap_fill_nxt;
      cl_fill_r <= cl_fill_nxt;
      hs_cnt_r  <= hs_cnt_nxt;
      act_r     <= act_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    rk_r   <= rk_nxt;
    cnt_r  <= cnt_nxt;
    nap_r  <= nap_nxt;
    ncl_r  <= ncl_nxt;
    hs_r   <= hs_nxt;
    full_r <= full_nxt;
    sel_r  <= sel_nxt;
    if (load) begin
      o_rk_r     <= rk_r;
      o_cnt_r    <= cnt_r;
      o_nap_r    <= nap_r;
      o_ncl_r    <= ncl_r;
      o_hs_r     <= hs_r;
      o_full_r   <= full_r;
      o_ap_r     <= ap_fill_r;
      o_cl_r     <= cl_fill_r;
      o_hs_tot_r <= hs_cnt_r;
      o_act_r    <= act_r;
    end
  end

  // Shared lookup engine over the selected table
  assign srch_fill  = sel_r ? S_CW'(cl_fill_r) : S_CW'(ap_fill_r);
  assign srch_rdata = sel_r ? cl_rdata : ap_rdata;

  wfm_search #(
    .CNT_W  (S_CW),
    .ADDR_W (S_AW)
  ) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (srch_start),
    .key     (key_r),
    .fill    (srch_fill),
    .rd_data (srch_rdata),
    .rd_addr (srch_addr),
    .stat    (srch_stat)
  );

  wfm_table #(
    .DEPTH  (AP_ENTRIES),
    .ADDR_W (AP_AW)
  ) u_ap_table (
    .clk     (clk),
    .wr_en   (ap_we),
    .wr_addr (AP_AW'(ap_fill_r)),
    .wr_data (key_r),
    .rd_addr (AP_AW'(srch_addr)),
    .rd_data (ap_rdata)
  );

  wfm_table #(
    .DEPTH  (CLIENT_ENTRIES),
    .ADDR_W (CL_AW)
  ) u_cl_table (
    .clk     (clk),
    .wr_en   (cl_we),
    .wr_addr (CL_AW'(cl_fill_r)),
    .wr_data (key_r),
    .rd_addr (CL_AW'(srch_addr)),
    .rd_data (cl_rdata)
  );

  assign out_valid           = ov_r;
  assign out_report_kind     = o_rk_r;
  assign out_frame_counted   = o_cnt_r;
  assign out_new_ap          = o_nap_r;
  assign out_new_client      = o_ncl_r;
  assign out_handshake_seen  = o_hs_r;
  assign out_table_full      = o_full_r;
  assign out_ap_total        = o_ap_r;
  assign out_client_total    = o_cl_r;
  assign out_handshake_total = o_hs_tot_r;
  assign out_activity_count  = o_act_r;

endmodule

FILE: rtl/wfm_checker.sv
// Port-level checks for the frame monitor, bound to the top level.
// Depends only on the ports of wifi_frame_monitor_core.
module wfm_checker #(
  parameter int AP_CW = 7,
  parameter int CL_CW = 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_report_kind,
  input logic             out_frame_counted,
  input logic             out_new_ap,
  input logic             out_new_client,
  input logic             out_handshake_seen,
  input logic             out_table_full,
  input logic [AP_CW-1:0] out_ap_total,
  input logic [CL_CW-1:0] out_client_total,
  input logic [31:0]      out_handshake_total,
  input logic [31:0]      out_activity_count
);

  // No word is shown right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ap_total) &&
    $stable(out_client_total) && $stable(out_handshake_total) &&
    $stable(out_activity_count) && $stable(out_report_kind))
    else $error("stalled word changed");

  // Epoch reports carry no frame flags
  a_epoch_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_report_kind |-> !(out_frame_counted || out_new_ap ||
    out_new_client || out_handshake_seen || out_table_full))
    else $error("epoch report with frame flags");

  // Table and handshake events only on counted frames
  a_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_new_ap || out_new_client || out_handshake_seen ||
    out_table_full) |-> out_frame_counted)
    else $error("frame event on uncounted frame");

  // A frame inserts into at most one table
  a_one_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_new_ap && out_new_client))
    else $error("insert into both tables");

endmodule

bind wifi_frame_monitor_core wfm_checker #(
  .AP_CW ($clog2(AP_ENTRIES + 1)),
  .CL_CW ($clog2(CLIENT_ENTRIES + 1))
) u_wfm_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_report_kind     (out_report_kind),
  .out_frame_counted   (out_frame_counted),
  .out_new_ap          (out_new_ap),
  .out_new_client      (out_new_client),
  .out_handshake_seen  (out_handshake_seen),
  .out_table_full      (out_table_full),
  .out_ap_total        (out_ap_total),
  .out_client_total    (out_client_total),
  .out_handshake_total (out_handshake_total),
  .out_activity_count  (out_activity_count)
);

FILE: tb/sv/wifi_frame_monitor_core_tb.sv
// Testbench for wifi_frame_monitor_core: a directed frame table, then random frames,
// every result word checked against a planned report or a prediction of counters and tables.
// Depends on wfm_pkg and the wifi_frame_monitor_core RTL.
module wifi_frame_monitor_core_tb;
  import wfm_pkg::*;

  localparam int AP_N  = 64;
  localparam int STA_N = 128;
  localparam int AP_W  = $clog2(AP_N + 1);
  localparam int STA_W = $clog2(STA_N + 1);

  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;

  localparam int HOLD_CYCLES = 500;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = AP_N + STA_N + 16;
  localparam int RAND_WORDS  = 300;

  typedef struct packed {
    logic               rkind;
    logic               counted;
    logic               new_ap;
    logic               new_client;
    logic               hs_seen;
    logic               full;
    logic [AP_W-1:0]    ap_total;
    logic [STA_W-1:0]   sta_total;
    logic [31:0]        hs_total;
    logic [31:0]        act_total;
  } report_t;

  // One frame, or one epoch tick when tick is set
  typedef struct packed {
    bit          tick;
    bit          fixed;
    logic [7:0]  fc;
    logic [1:0]  kind_early;
    logic [1:0]  kind;
    int          len;
    mac_t        src;
    mac_t        bssid;
    int          eapol_at;
    int          tick_at;
    report_t     want;
  } frame_row_t;

  localparam mac_t MAC_A = 48'h00_1A_2B_3C_4D_5E;
  localparam mac_t MAC_B = 48'h02_C0_FF_EE_00_01;
  localparam mac_t STA_1 = 48'h3C_22_FB_10_20_30;
  localparam mac_t STA_2 = 48'hA4_83_E7_01_02_03;
  localparam mac_t STA_3 = 48'h7E_00_11_22_33_44;
  localparam mac_t STA_4 = 48'hDC_A6_32_55_66_77;
  localparam mac_t ONES  = 48'hFFFF_FFFF_FFFF;

  localparam report_t ZERO_FRAME = '0;
  localparam report_t ZERO_EPOCH = '{REPORT_EPOCH, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                     7'd0, 8'd0, 32'd0, 32'd0};

  // tick, fixed, fc, kind_early, kind, len, src, bssid, eapol_at, tick_at, want
  localparam frame_row_t PLAN [21] = '{
    '{1'b1, 1'b1, 8'h00, KIND_MGMT, KIND_MGMT, 0, '0, '0, -1, -1, ZERO_EPOCH},
    '{1'b0, 1'b1, BEACON_FC, KIND_MGMT, KIND_MGMT, 23, '0, MAC_A, -1, -1, ZERO_FRAME},
    '{1'b0, 1'b1, BEACON_FC, KIND_MGMT, KIND_OTHER, 40, '0, MAC_A, -1, -1, ZERO_FRAME},
    '{1'b0, 1'b1, BEACON_FC, KIND_MGMT, KIND_RSVD, 40, '0, MAC_A, -1, -1, ZERO_FRAME},
    '{1'b0, 1'b1, BEACON_FC, KIND_MGMT, KIND_MGMT, 36, '0, MAC_A, -1, -1,
      '{REPORT_FRAME, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 8'd0, 32'd0, 32'd1}},
    '{1'b0, 1'b1, BEACON_FC, KIND_MGMT, KIND_MGMT, 37, '0, MAC_A, -1, -1,
      '{REPORT_FRAME, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 7'd1, 8'd0, 32'd0, 32'd2}},
    '{1'b0, 1'b0, BEACON_FC, KIND_MGMT, KIND_MGMT, 60, '0, MAC_A, -1, -1, '0},
    '{1'b0, 1'b0, 8'h08, KIND_DATA, KIND_DATA, 24, STA_1, MAC_A, -1, -1, '0},
    '{1'b0, 1'b0, 8'h88, KIND_DATA, KIND_DATA, 40, STA_1, MAC_A, 24, -1, '0},
    '{1'b0, 1'b0, 8'h08, KIND_DATA, KIND_DATA, 40, STA_2, MAC_A, 23, -1, '0},
    '{1'b0, 1'b0, 8'h08, KIND_OTHER, KIND_MGMT, 30, STA_2, MAC_B, -1, -1, '0},
    '{1'b0, 1'b0, 8'h40, KIND_DATA, KIND_DATA, 24, STA_3, MAC_B, -1, -1, '0},
    '{1'b1, 1'b0, 8'h00, KIND_MGMT, KIND_MGMT, 0, '0, '0, -1, -1, '0},
    '{1'b0, 1'b0, 8'hC8, KIND_DATA, KIND_DATA, 40, STA_3, MAC_B, 30, 31, '0},
    '{1'b0, 1'b0, BEACON_FC, KIND_MGMT, KIND_MGMT, 37, '0, ONES, -1, -1, '0},
    '{1'b0, 1'b0, 8'hFB, KIND_DATA, KIND_DATA, 24, ONES, '0, -1, -1, '0},
    '{1'b0, 1'b0, 8'h08, KIND_DATA, KIND_DATA, 24, '0, ONES, -1, -1, '0},
    '{1'b0, 1'b0, BEACON_FC, KIND_MGMT, KIND_MGMT, 64, STA_4, MAC_B, -1, -1, '0},
    '{1'b0, 1'b0, 8'h08, KIND_DATA, KIND_DATA, 100, STA_4, MAC_B, 97, -1, '0},
    '{1'b0, 1'b0, BEACON_FC, KIND_MGMT, KIND_MGMT, 1, '0, '0, -1, -1, '0},
    '{1'b1, 1'b0, 8'h00, KIND_MGMT, KIND_MGMT, 0, '0, '0, -1, -1, '0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_func = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic [1:0] in_frame_kind = 2'd0;
  logic in_last_byte = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_report_kind;
  logic out_frame_counted;
  logic out_new_ap;
  logic out_new_client;
  logic out_handshake_seen;
  logic out_table_full;
  logic [AP_W-1:0] out_ap_total;
  logic [STA_W-1:0] out_client_total;
  logic [31:0] out_handshake_total;
  logic [31:0] out_activity_count;

  // Predicted monitor state
  logic [15:0] frm_pos = '0;
  logic [7:0] fc_byte = '0;
  mac_t src_sr = '0;
  mac_t bssid_sr = '0;
  logic [7:0] prev_b = '0;
  bit eapol_hit = 1'b0;
  mac_t ap_seen[$];
  mac_t sta_seen[$];
  logic [31:0] hs_cnt = '0;
  logic [31:0] act_cnt = '0;

  report_t reports_due[$];
  report_t head_rep;
  mac_t addr_pool[$];
  int fail_cnt = 0;
  int words_taken = 0;
  int quiet_cycles = 0;
  bit tx_idle = 1'b1;
  logic rx_idle_en = 1'b1;
  int hold_ask = 0;
  int hold_seen = 0;
  int rx_gap = 0;

  wifi_frame_monitor_core #(
    .AP_ENTRIES    (AP_N),
    .CLIENT_ENTRIES(STA_N)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_data_byte       (in_data_byte),
    .in_frame_kind      (in_frame_kind),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_report_kind    (out_report_kind),
    .out_frame_counted  (out_frame_counted),
    .out_new_ap         (out_new_ap),
    .out_new_client     (out_new_client),
    .out_handshake_seen (out_handshake_seen),
    .out_table_full     (out_table_full),
    .out_ap_total       (out_ap_total),
    .out_client_total   (out_client_total),
    .out_handshake_total(out_handshake_total),
    .out_activity_count (out_activity_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit listed(input mac_t tab[$], input mac_t key);
    foreach (tab[i]) begin
      if (tab[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the predicted state by one accepted word; return 1 when it yields a report
  function automatic bit predict_report(input logic f, input logic [7:0] b,
                                        input logic [1:0] k, input logic l,
                                        output report_t rep);
    logic [15:0] pos;
    int len;
    rep = '0;
    if (f == FUNC_EPOCH) begin
      rep.rkind = REPORT_EPOCH;
      rep.ap_total = AP_W'(ap_seen.size());
      rep.sta_total = STA_W'(sta_seen.size());
      rep.hs_total = hs_cnt;
      rep.act_total = act_cnt;
      act_cnt = '0;
      return 1'b1;
    end
    pos = frm_pos;
    if (pos == 16'd0) fc_byte = b;
    if (pos >= SRC_FIRST && pos <= SRC_LAST) src_sr = {src_sr[39:0], b};
    if (pos >= BSSID_FIRST && pos <= BSSID_LAST) bssid_sr = {bssid_sr[39:0], b};
    if (pos >= EAPOL_MIN_OFF && prev_b == EAPOL_HI && b == EAPOL_LO) eapol_hit = 1'b1;
    prev_b = b;
    if (frm_pos != 16'hFFFF) frm_pos = frm_pos + 16'd1;
    if (!l) return 1'b0;

    len = int'(pos) + 1;
    rep.rkind = REPORT_FRAME;
    if ((k == KIND_MGMT || k == KIND_DATA) && len >= COUNT_MIN_LEN) begin
      rep.counted = 1'b1;
      if (act_cnt != 32'hFFFF_FFFF) act_cnt = act_cnt + 32'd1;
      // Beacon: learn the BSSID
      if (fc_byte == BEACON_FC && len > BEACON_MIN_LEN && !listed(ap_seen, bssid_sr)) begin
        if (ap_seen.size() < AP_N) begin
          ap_seen.push_back(bssid_sr);
          rep.new_ap = 1'b1;
        end else begin
          rep.full = 1'b1;
        end
      end
      // Data type: learn the source and look for EAPOL
      if ((fc_byte & DTYPE_MASK) == DTYPE_VAL) begin
        if (!listed(sta_seen, src_sr)) begin
          if (sta_seen.size() < STA_N) begin
            sta_seen.push_back(src_sr);
            rep.new_client = 1'b1;
          end else begin
            rep.full = 1'b1;
          end
        end
        if (eapol_hit) begin
          rep.hs_seen = 1'b1;
          hs_cnt = hs_cnt + 32'd1;
        end
      end
    end
    rep.ap_total = AP_W'(ap_seen.size());
    rep.sta_total = STA_W'(sta_seen.size());
    rep.hs_total = hs_cnt;
    rep.act_total = act_cnt;
    frm_pos = '0;
    prev_b = '0;
    eapol_hit = 1'b0;
    return 1'b1;
  endfunction

  // Offer one word, hold it until accepted, then queue its expected report
  task automatic push_word(input logic f, input logic [7:0] b, input logic [1:0] k,
                           input logic l, input bit typed, input report_t typed_rep);
    report_t rep;
    bit has;
    if (tx_idle && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_data_byte <= b;
    in_frame_kind <= k;
    in_last_byte <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_taken++;
    has = predict_report(f, b, k, l, rep);
    if (has) reports_due.push_back(typed ? typed_rep : rep);
  endtask

  task automatic send_frame(input frame_row_t r, input bit noisy);
    logic [7:0] b;
    logic [1:0] k;
    if (r.tick) begin
      push_word(FUNC_EPOCH, 8'($urandom()), 2'($urandom()), 1'($urandom()), r.fixed, r.want);
      return;
    end
    for (int i = 0; i < r.len; i++) begin
      if (i == r.tick_at) begin
        push_word(FUNC_EPOCH, 8'($urandom()), 2'($urandom()), 1'($urandom()), 1'b0, '0);
      end
      if (i == 0) b = r.fc;
      else if (i >= SRC_FIRST && i <= SRC_LAST) b = r.src[8*(SRC_LAST-i) +: 8];
      else if (i >= BSSID_FIRST && i <= BSSID_LAST) b = r.bssid[8*(BSSID_LAST-i) +: 8];
      else if (r.eapol_at >= 0 && i == r.eapol_at) b = EAPOL_HI;
      else if (r.eapol_at >= 0 && i == r.eapol_at + 1) b = EAPOL_LO;
      else begin
        b = 8'($urandom());
        // keep planned frames free of stray EAPOL pairs
        if (!noisy && b == EAPOL_HI) b = 8'h00;
      end
      k = (i == r.len - 1) ? r.kind : r.kind_early;
      push_word(FUNC_BYTE, b, k, (i == r.len - 1), r.fixed, r.want);
    end
  endtask

  // Reuse a known address now and then so that lookups hit
  function automatic mac_t pick_addr();
    mac_t m;
    logic [31:0] lo;
    if (addr_pool.size() != 0 && $urandom_range(0, 9) < 4) begin
      return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    end
    lo = $urandom();
    m = {$urandom(), lo[15:0]};
    addr_pool.push_back(m);
    return m;
  endfunction

  task automatic random_frame(output frame_row_t r, output bit noisy);
    int pick;
    r = '0;
    r.eapol_at = -1;
    r.tick_at = -1;
    noisy = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      r.tick = 1'b1;
      return;
    end
    r.src = pick_addr();
    r.bssid = pick_addr();
    if (pick < 15) begin
      noisy = 1'b1;
      r.fc = 8'($urandom());
      r.kind_early = 2'($urandom());
      r.kind = 2'($urandom());
      r.len = $urandom_range(1, 70);
    end else if (pick < 50) begin
      r.fc = BEACON_FC;
      r.kind_early = KIND_MGMT;
      r.kind = KIND_MGMT;
      r.len = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 100) : $urandom_range(37, 48);
    end else begin
      r.fc = (8'($urandom()) & ~DTYPE_MASK) | DTYPE_VAL;
      r.kind_early = KIND_DATA;
      r.kind = KIND_DATA;
      r.len = $urandom_range(24, 48);
      if ($urandom_range(0, 2) == 0) r.eapol_at = $urandom_range(22, r.len - 2);
    end
    if (!noisy && $urandom_range(0, 9) == 0) r.kind_early = 2'($urandom());
    if (!noisy && $urandom_range(0, 19) == 0) r.kind = 2'($urandom_range(2, 3));
    if ($urandom_range(0, 19) == 0) r.tick_at = $urandom_range(0, r.len - 1);
  endtask

  // Drop valid and wait until every expected report has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, plus a long hold when asked
  always @(posedge clk) begin
    if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_ask) begin
      hold_seen <= hold_ask;
      rx_gap <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 11) == 0) begin
      rx_gap <= $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // Compare each result word with the oldest expected report
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (reports_due.size() == 0) begin
        $error("result word with no report expected");
        fail_cnt++;
      end else begin
        head_rep = reports_due.pop_front();
        check_field("report_kind", 32'(head_rep.rkind), 32'(out_report_kind));
        check_field("frame_counted", 32'(head_rep.counted), 32'(out_frame_counted));
        check_field("new_ap", 32'(head_rep.new_ap), 32'(out_new_ap));
        check_field("new_client", 32'(head_rep.new_client), 32'(out_new_client));
        check_field("handshake_seen", 32'(head_rep.hs_seen), 32'(out_handshake_seen));
        check_field("table_full", 32'(head_rep.full), 32'(out_table_full));
        check_field("ap_total", 32'(head_rep.ap_total), 32'(out_ap_total));
        check_field("client_total", 32'(head_rep.sta_total), 32'(out_client_total));
        check_field("handshake_total", head_rep.hs_total, out_handshake_total);
        check_field("activity_count", head_rep.act_total, out_activity_count);
      end
    end
  end

  // Count cycles in which neither side moves a word
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("wifi_frame_monitor_core test failed");
    $finish;
  end

  initial begin
    frame_row_t row;
    bit noisy;
    int frames;
    int rand_base;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames
    foreach (PLAN[r]) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle_en <= ($urandom_range(0, 3) != 0);
      send_frame(PLAN[r], 1'b0);
    end
    drain();

    // Random frames up to the word budget
    frames = 0;
    rand_base = words_taken;
    while (words_taken - rand_base < RAND_WORDS && frames < 4000) begin
      if (frames == 2) hold_ask <= hold_ask + 1;
      if (frames == 5) drain();
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle_en <= ($urandom_range(0, 3) != 0);
      random_frame(row, noisy);
      send_frame(row, noisy);
      frames++;
    end

    // Closing stretch at full rate
    tx_idle = 1'b0;
    rx_idle_en <= 1'b0;
    repeat (4) begin
      random_frame(row, noisy);
      send_frame(row, noisy);
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_cnt == 0) $display("wifi_frame_monitor_core test passed");
    else $display("wifi_frame_monitor_core test failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/wfm_pkg.sv
rtl/wfm_table.sv
rtl/wfm_search.sv
rtl/wifi_frame_monitor_core.sv
rtl/wfm_checker.sv
tb/sv/wifi_frame_monitor_core_tb.sv
